>>> design/acb64_pkg.sv
// Shared types, round constants and helpers for the Alzette 64-bit block cipher.
// No dependencies; imported by alzette_block_cipher_64.
`default_nettype none

package acb64_pkg;

  localparam int WORD_W         = 32;
  localparam int CFG_ADDR_W     = 3;
  localparam int DEFAULT_ROUNDS = 10;
  localparam int NUM_RCON       = 5;
  localparam int BOX_STEPS      = 4;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_KEY0   = 3'd0,
    REG_KEY1   = 3'd1,
    REG_KEY2   = 3'd2,
    REG_KEY3   = 3'd3,
    REG_ROUNDS = 3'd4
  } cfg_reg_e;

  // Round constants, selected by round index mod 5
  localparam logic [WORD_W-1:0] RCON [NUM_RCON] = '{
    32'hB7E15162, 32'hBF715880, 32'h38B4DA56, 32'h324E7738, 32'hBB1185EB
  };

  // Alzette step j: x += rotr(y, ROT_A[j]); y ^= rotr(x, ROT_B[j]); x ^= c
  localparam int unsigned ROT_A [BOX_STEPS] = '{31, 17, 0, 24};
  localparam int unsigned ROT_B [BOX_STEPS] = '{24, 17, 31, 16};

  // One pipeline slot: operation plus the two block words
  typedef struct packed {
    logic              decrypt;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] x;
  } stage_t;

  function automatic logic [WORD_W-1:0] rotr(logic [WORD_W-1:0] v, int unsigned n);
    return (v >> n) | (v << (WORD_W - n));
  endfunction

endpackage

`default_nettype wire

>>> design/alzette_block_cipher_64.sv
// Top level of the Alzette 64-bit block cipher: one Alzette step per pipeline stage.
// Depends on acb64_pkg.
`default_nettype none

// Channel     Dir  Contents (lowest bit first)
// s_axis      in   tdata: word_x_in, word_y_in; tuser: func (1 = decrypt)
// m_axis      out  tdata: word_x_out, word_y_out
// cfg         in   cfg_we_i, cfg_addr_i, cfg_wdata_i (write only)
//
// One item enters per cycle while s_axis_tready is high; each of the 4*MAX_ROUNDS
// stages performs one 32-bit add/subtract step of the Alzette box.
// Rounds beyond the configured count pass through their stages unchanged.
// A two-entry output buffer absorbs back-pressure; when its second entry is
// full the whole pipeline holds and s_axis_tready drops.
// Reset clears valid bits, keys to zero and the round count to ten.

module alzette_block_cipher_64 #(
  parameter int MAX_ROUNDS = 16
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    cfg_we_i,
  input  wire  [acb64_pkg::CFG_ADDR_W-1:0]       cfg_addr_i,
  input  wire  [acb64_pkg::WORD_W-1:0]           cfg_wdata_i,
  input  wire                                    s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire  [2*acb64_pkg::WORD_W-1:0]         s_axis_tdata,  // word_x_in, word_y_in
  input  wire                                    s_axis_tuser,  // func
  output logic                                   m_axis_tvalid,
  input  wire                                    m_axis_tready,
  output logic [2*acb64_pkg::WORD_W-1:0]         m_axis_tdata   // word_x_out, word_y_out
);
  import acb64_pkg::*;

  localparam int NS = BOX_STEPS * MAX_ROUNDS;
  localparam int RW = $clog2(MAX_ROUNDS + 1);
  localparam int CW = (RW > 5) ? RW : 5;

  // Configuration registers
  logic [WORD_W-1:0] key_q [4];
  logic [4:0]        rounds_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q[0] <= '0;
      key_q[1] <= '0;
      key_q[2] <= '0;
      key_q[3] <= '0;
      rounds_q <= 5'(DEFAULT_ROUNDS);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_KEY0:   key_q[0] <= cfg_wdata_i;
        REG_KEY1:   key_q[1] <= cfg_wdata_i;
        REG_KEY2:   key_q[2] <= cfg_wdata_i;
        REG_KEY3:   key_q[3] <= cfg_wdata_i;
        REG_ROUNDS: rounds_q <= cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  // Effective round count: zero means ten, then clamp to MAX_ROUNDS
  logic [CW-1:0]         rounds_raw;
  logic [CW-1:0]         rounds_eff;
  logic [MAX_ROUNDS-1:0] enc_act;
  logic [MAX_ROUNDS-1:0] dec_act;

  always_comb begin
    rounds_raw = (rounds_q == 5'd0) ? CW'(DEFAULT_ROUNDS) : CW'(rounds_q);
    rounds_eff = (rounds_raw > CW'(MAX_ROUNDS)) ? CW'(MAX_ROUNDS) : rounds_raw;
    for (int k = 0; k < MAX_ROUNDS; k++) begin
      enc_act[k] = CW'(k) < rounds_eff;
      dec_act[k] = CW'(k) >= (CW'(MAX_ROUNDS) - rounds_eff);
    end
  end

  // Final key words (round index = round count)
  logic [WORD_W-1:0] fin_kx;
  logic [WORD_W-1:0] fin_ky;
  assign fin_kx = rounds_eff[0] ? key_q[2] : key_q[0];
  assign fin_ky = rounds_eff[0] ? key_q[3] : key_q[1];

  // Pipeline control: everything advances unless the output buffer is full
  logic   adv;
  logic   skid_v_q;
  logic   out_v_q;
  logic   [NS:0] valid_q;
  stage_t stg_q [NS+1];
  stage_t skid_q;
  stage_t out_q;

  assign adv           = !skid_v_q;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[NS-1:0], s_axis_tvalid};
    end
  end

  // Entry stage: decryption starts with the final-round key addition
  always_ff @(posedge clk_i) begin
    if (adv) begin
      stg_q[0].decrypt <= s_axis_tuser;
      stg_q[0].x <= s_axis_tdata[WORD_W-1:0] ^ (s_axis_tuser ? fin_kx : '0);
      stg_q[0].y <= s_axis_tdata[2*WORD_W-1:WORD_W] ^ (s_axis_tuser ? fin_ky : '0);
    end
  end

  // Step stages: stage s is step s%4 of forward round s/4,
  // or step s%4 of inverse round MAX_ROUNDS-1-s/4
  for (genvar s = 0; s < NS; s++) begin : g_step
    localparam int RndF = s / BOX_STEPS;
    localparam int Stp  = s % BOX_STEPS;
    localparam int RndI = MAX_ROUNDS - 1 - RndF;

    logic [WORD_W-1:0] fx, fy, ix, iy;
    stage_t nxt;

    always_comb begin
      // forward
      fx = stg_q[s].x;
      fy = stg_q[s].y;
      if (Stp == 0) begin
        fx = fx ^ WORD_W'(RndF) ^ (((RndF % 2) == 1) ? key_q[2] : key_q[0]);
        fy = fy ^ (((RndF % 2) == 1) ? key_q[3] : key_q[1]);
      end
      fx = fx + rotr(fy, ROT_A[Stp]);
      fy = fy ^ rotr(fx, ROT_B[Stp]);
      fx = fx ^ RCON[RndF % NUM_RCON];

      // inverse
      ix = stg_q[s].x ^ RCON[RndI % NUM_RCON];
      iy = stg_q[s].y ^ rotr(ix, ROT_B[BOX_STEPS-1-Stp]);
      ix = ix - rotr(iy, ROT_A[BOX_STEPS-1-Stp]);
      if (Stp == BOX_STEPS - 1) begin
        ix = ix ^ WORD_W'(RndI) ^ (((RndI % 2) == 1) ? key_q[2] : key_q[0]);
        iy = iy ^ (((RndI % 2) == 1) ? key_q[3] : key_q[1]);
      end

      nxt = stg_q[s];
      if (stg_q[s].decrypt) begin
        if (dec_act[RndF]) begin
          nxt.x = ix;
          nxt.y = iy;
        end
      end else begin
        if (enc_act[RndF]) begin
          nxt.x = fx;
          nxt.y = fy;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        stg_q[s+1] <= nxt;
      end
    end
  end

  // Exit: encryption ends with the final-round key addition
  stage_t fin;
  always_comb begin
    fin   = stg_q[NS];
    fin.x = stg_q[NS].x ^ (stg_q[NS].decrypt ? '0 : fin_kx);
    fin.y = stg_q[NS].y ^ (stg_q[NS].decrypt ? '0 : fin_ky);
  end

  // Output register plus skid entry
  logic out_v_d;
  logic skid_v_d;
  logic load_out;
  logic load_skid;
  logic drain_skid;

  always_comb begin
    out_v_d    = out_v_q;
    skid_v_d   = skid_v_q;
    load_out   = 1'b0;
    load_skid  = 1'b0;
    drain_skid = 1'b0;
    if (adv) begin
      if (valid_q[NS]) begin
        if (!out_v_q || m_axis_tready) begin
          out_v_d  = 1'b1;
          load_out = 1'b1;
        end else begin
          skid_v_d  = 1'b1;
          load_skid = 1'b1;
        end
      end else if (m_axis_tready) begin
        out_v_d = 1'b0;
      end
    end else if (m_axis_tready) begin
      skid_v_d   = 1'b0;
      drain_skid = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= fin;
    end else if (drain_skid) begin
      out_q <= skid_q;
    end
    if (load_skid) begin
      skid_q <= fin;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_q.y, out_q.x};

endmodule

`default_nettype wire

>>> design/acb64_checker.sv
// Port-level checks for alzette_block_cipher_64, attached by bind.
// No package dependency.
`default_nettype none

module acb64_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [63:0] m_axis_tdata
);

  // A held result keeps its data
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed while stalled");

  // Input is only refused when a result is waiting
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input refused with no output pending");

  // Buffer drains by the next cycle once the sink takes an item
  a_ready_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready && m_axis_tready |=> s_axis_tready)
    else $error("input stayed blocked after output was taken");

  // Nothing comes out once reset has been seen at an edge
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("output valid during reset");

  // Pipeline latency keeps the output quiet right after reset
  a_reset_exit: assert property (@(posedge clk_i)
    $rose(rst_ni) |=> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind alzette_block_cipher_64 acb64_checker u_acb64_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
